// ===== rtl/sle_pkg.sv =====
// Shared constants and types for the serial line editor.
package sle_pkg;

   localparam int COUNT_W = 6;
   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;
   localparam int LINE_CAPACITY_DEF = 48;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 6'd48;

   localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END = 2'd2;

   localparam logic [BYTE_W-1:0] CHR_CTRL_C = 8'h03;
   localparam logic [BYTE_W-1:0] CHR_BS = 8'h08;
   localparam logic [BYTE_W-1:0] CHR_TAB = 8'h09;
   localparam logic [BYTE_W-1:0] CHR_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHR_ESC = 8'h1B;
   localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_UP = 8'h41;
   localparam logic [BYTE_W-1:0] CHR_DOWN = 8'h42;
   localparam logic [BYTE_W-1:0] CHR_RIGHT = 8'h43;
   localparam logic [BYTE_W-1:0] CHR_LEFT = 8'h44;
   localparam logic [BYTE_W-1:0] CHR_BRACKET = 8'h5B;
   localparam logic [BYTE_W-1:0] CHR_CARET = 8'h5E;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic [COUNT_W-1:0] wr_addr;
      logic [COUNT_W-1:0] rd_addr;
      logic [BYTE_W-1:0] wr_data;
   } store_req_type;

endpackage

// ===== rtl/sle_line_store.sv =====
// Line buffer memory with one write port and one registered read port.
module sle_line_store
   import sle_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
   input  logic clock,
   input  store_req_type store_req,
   output logic [BYTE_W-1:0] rd_data
);

   localparam int ADDR_W = $clog2(LINE_CAPACITY);

   logic [BYTE_W-1:0] mem [LINE_CAPACITY];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr[ADDR_W-1:0]] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sle_sequencer.sv =====
// Sequencer that edits the line, checks arrow keys and walks the buffer at line end.
module sle_sequencer
   import sle_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [COUNT_W-1:0] limit,
   input  logic req_valid,
   output logic req_stall,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [KIND_W-1:0] rsp_out_kind,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic [COUNT_W-1:0] rsp_line_length,
   output logic rsp_last,
   output store_req_type store_req,
   input  logic [BYTE_W-1:0] store_rdata
);

   localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(LINE_CAPACITY);
   localparam logic [COUNT_W-1:0] ONE = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] TWO = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] THREE = COUNT_W'(3);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ARW_A,
      ST_ARW_B,
      ST_ARW_C,
      ST_ECHO,
      ST_BS_1,
      ST_BS_2,
      ST_BS_3,
      ST_CARET,
      ST_CTRL_C,
      ST_SKIP_RD,
      ST_SKIP_CHK,
      ST_LINE_RD,
      ST_LINE_OUT,
      ST_END
   } state_type;

   state_type state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [BYTE_W-1:0] first_ff, first_in;
   logic fin_ff, fin_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [COUNT_W-1:0] out_len_ff, out_len_in;
   logic last_ff, last_in;

   logic can_load;
   logic arrow;
   logic [COUNT_W-1:0] new_count;
   logic is_store;

   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign is_store = (req_rx_byte != CHR_TAB) && (req_rx_byte != CHR_CTRL_C) &&
                     (req_rx_byte != CHR_BS);

   always_comb begin
      arrow = (count_ff >= THREE) && (first_ff == CHR_ESC) && (store_rdata == CHR_BRACKET) &&
              (byte_ff inside {CHR_UP, CHR_DOWN, CHR_RIGHT, CHR_LEFT});
      new_count = arrow ? (count_ff - THREE) : count_ff;
   end

   always_comb begin
      store_req = '0;
      store_req.wr_addr = count_ff;
      store_req.wr_data = req_rx_byte;
      store_req.rd_addr = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            store_req.wr_en = req_valid && is_store && (count_ff < CAPACITY);
         end
         ST_ARW_A: begin
            store_req.rd_en = (count_ff >= THREE);
            store_req.rd_addr = count_ff - THREE;
         end
         ST_ARW_B: begin
            store_req.rd_en = (count_ff >= THREE);
            store_req.rd_addr = count_ff - TWO;
         end
         ST_SKIP_RD: begin
            store_req.rd_en = (idx_ff != count_ff);
         end
         ST_LINE_RD: begin
            store_req.rd_en = 1'b1;
         end
         default: begin
            store_req.rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      len_in = len_ff;
      byte_in = byte_ff;
      first_in = first_ff;
      fin_in = fin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in = kind_ff;
      out_byte_in = out_byte_ff;
      out_len_in = out_len_ff;
      last_in = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_rx_byte;
               case (req_rx_byte)
                  CHR_TAB: begin
                     state_in = ST_IDLE;
                  end
                  CHR_CTRL_C: begin
                     count_in = '0;
                     state_in = ST_CARET;
                  end
                  CHR_BS: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - ONE;
                        fin_in = (count_ff - ONE) >= limit;
                        state_in = ST_BS_1;
                     end
                  end
                  default: begin
                     if (count_ff < CAPACITY) begin
                        count_in = count_ff + ONE;
                     end
                     state_in = ST_ARW_A;
                  end
               endcase
            end
         end
         ST_ARW_A: begin
            state_in = ST_ARW_B;
         end
         ST_ARW_B: begin
            first_in = store_rdata;
            state_in = ST_ARW_C;
         end
         ST_ARW_C: begin
            count_in = new_count;
            fin_in = (new_count >= limit) || (byte_ff == CHR_CR) || (byte_ff == CHR_LF);
            idx_in = '0;
            if (!arrow && (byte_ff != CHR_ESC) && (byte_ff != CHR_BRACKET)) begin
               state_in = ST_ECHO;
            end else if (fin_in) begin
               state_in = ST_SKIP_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ECHO: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               kind_in = KIND_ECHO;
               out_byte_in = byte_ff;
               out_len_in = '0;
               last_in = !fin_ff;
               idx_in = '0;
               state_in = fin_ff ? ST_SKIP_RD : ST_IDLE;
            end
         end
         ST_BS_1, ST_BS_2, ST_BS_3: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               kind_in = KIND_ECHO;
               out_byte_in = (state_ff == ST_BS_2) ? CHR_SPACE : CHR_BS;
               out_len_in = '0;
               last_in = (state_ff == ST_BS_3) && !fin_ff;
               idx_in = '0;
               case (state_ff)
                  ST_BS_1: state_in = ST_BS_2;
                  ST_BS_2: state_in = ST_BS_3;
                  default: state_in = fin_ff ? ST_SKIP_RD : ST_IDLE;
               endcase
            end
         end
         ST_CARET, ST_CTRL_C: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               kind_in = KIND_ECHO;
               out_byte_in = (state_ff == ST_CARET) ? CHR_CARET : CHR_RIGHT;
               out_len_in = '0;
               last_in = 1'b0;
               idx_in = '0;
               state_in = (state_ff == ST_CARET) ? ST_CTRL_C : ST_SKIP_RD;
            end
         end
         ST_SKIP_RD: begin
            if (idx_ff == count_ff) begin
               len_in = count_ff - idx_ff + COUNT_W'(idx_ff != '0);
               state_in = ST_END;
            end else begin
               state_in = ST_SKIP_CHK;
            end
         end
         ST_SKIP_CHK: begin
            if (store_rdata == CHR_SPACE) begin
               idx_in = idx_ff + ONE;
               state_in = ST_SKIP_RD;
            end else begin
               len_in = count_ff - idx_ff + COUNT_W'(idx_ff != '0);
               state_in = ST_LINE_OUT;
            end
         end
         ST_LINE_RD: begin
            state_in = ST_LINE_OUT;
         end
         ST_LINE_OUT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               kind_in = KIND_LINE;
               out_byte_in = store_rdata;
               out_len_in = '0;
               last_in = 1'b0;
               idx_in = idx_ff + ONE;
               state_in = ((idx_ff + ONE) == count_ff) ? ST_END : ST_LINE_RD;
            end
         end
         ST_END: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               kind_in = KIND_END;
               out_byte_in = '0;
               out_len_in = len_ff;
               last_in = 1'b1;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      len_ff <= len_in;
      byte_ff <= byte_in;
      first_ff <= first_in;
      fin_ff <= fin_in;
      kind_ff <= kind_in;
      out_byte_ff <= out_byte_in;
      out_len_ff <= out_len_in;
      last_ff <= last_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_line_length = out_len_ff;
   assign rsp_last = last_ff;

endmodule

// ===== rtl/serial_line_editor.sv =====
// Serial line editor: console byte editing with echo and line delivery.
// A tab, or a backspace on an empty line, leaves the state idle; a backspace or Ctrl-C
// echoes from ST_BS_1 or ST_CARET, and other bytes pass ST_ARW_A to ST_ARW_C first.
// At line end, output stalls can hold the walk over the stored bytes and the end record.
// Rate is set by the sequencer's walk of the single registered read port of the buffer.
// Synchronous active-high reset empties the line and sets the limit to 48.
module serial_line_editor
   import sle_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [KIND_W-1:0] rsp_out_kind,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic [COUNT_W-1:0] rsp_line_length,
   output logic rsp_last,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [COUNT_W-1:0] csr_line_limit
);

   localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(LINE_CAPACITY);

   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [COUNT_W-1:0] limit_eff;
   store_req_type store_req;
   logic [BYTE_W-1:0] store_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_valid) begin
         limit_in = csr_line_limit;
      end
      if (limit_ff == '0) begin
         limit_eff = COUNT_W'(1);
      end else if (limit_ff > CAPACITY) begin
         limit_eff = CAPACITY;
      end else begin
         limit_eff = limit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   sle_line_store #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_store (
      .clock(clock),
      .store_req(store_req),
      .rd_data(store_rdata)
   );

   sle_sequencer #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .limit(limit_eff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_kind(rsp_out_kind),
      .rsp_out_byte(rsp_out_byte),
      .rsp_line_length(rsp_line_length),
      .rsp_last(rsp_last),
      .store_req(store_req),
      .store_rdata(store_rdata)
   );

endmodule
